@@ sv/assert_macros.svh @@
// Assertion macros for the RTL files.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/dse_pkg.sv @@
// Shared constants and types of the statistics engine.
// No dependencies; imported by descriptive_statistics_engine_core.
package dse_pkg;

   localparam int MAX_SAMPLES = 64;
   localparam int SAMPLE_BITS = 16;
   localparam int ADDR_BITS   = $clog2(MAX_SAMPLES);
   localparam int CNT_BITS    = ADDR_BITS + 1;
   localparam int SUM_BITS    = 22;
   localparam int SQ_BITS     = 38;
   localparam int DIVN_BITS   = 52;   // dividend / quotient width
   localparam int DEN_BITS    = 12;   // n*(n-1) fits here
   localparam int VAR_BITS    = 40;
   localparam int MEAN_BITS   = 24;
   localparam int SD_BITS     = 24;
   localparam int SQRT_SRC    = 48;
   localparam int RSP_BITS    = 192;

   typedef enum logic [9:0] {
      ST_LOAD = 10'b0000000001,
      ST_MULT = 10'b0000000010,
      ST_VSET = 10'b0000000100,
      ST_VDIV = 10'b0000001000,
      ST_MSET = 10'b0000010000,
      ST_MDIV = 10'b0000100000,
      ST_SQRT = 10'b0001000000,
      ST_SCAN = 10'b0010000000,
      ST_STEP = 10'b0100000000,
      ST_EMIT = 10'b1000000000
   } state_type;

endpackage

@@ sv/descriptive_statistics_engine_core.sv @@
// Statistics engine top level: sample store, divider, root unit and scan sequencer.
// Depends on dse_pkg and assert_macros.svh.
//
//  channel | dir | ports                          | word
//  --------+-----+--------------------------------+-----------------------------
//  req     | in  | req_tvalid/tready/tdata/tlast  | one sample, tlast ends set
//  rsp     | out | rsp_tvalid/tready/tdata/tlast  | statistics + one mode value
//
// Loading: one sample word per cycle into the 64-entry store; tready drops after tlast.
// Then a multiply step, the variance divide (skipped below two samples), the mean divide,
// the bit-serial root, then store sweeps: one per distinct value plus one in the first
// pass, one per value up to the last mode in the second, with an emit step per mode that
// stretches while the output word is not taken (one word with no mode if none repeats).
// Synchronous reset, no clearing pass: only held entries are ever read; the next set may
// load while the final word of a run still waits.
`include "assert_macros.svh"

module descriptive_statistics_engine_core
   import dse_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [15:0]         req_tdata,   // [15:0] sample
   input  logic                req_tlast,   // last sample of the set
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // [6:0] count, [30:7] mean_q8, [47:31] median_x2, [63:48] minimum,
   // [79:64] maximum, [95:80] spread, [135:96] variance_q8,
   // [159:136] std_dev_q8, [175:160] mode_value, [182:176] mode_occurrences,
   // [189:183] mode_total, [191:190] zero
   output logic [RSP_BITS-1:0] rsp_tdata,
   output logic                rsp_tlast    // last_of_run
);

   // sample store
   logic [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic                   mem_we;

   state_type              state_ff, state_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [SQ_BITS-1:0]     sq_ff, sq_in;
   logic [44:0]            prod1_ff, prod1_in;
   logic [43:0]            prod2_ff, prod2_in;

   // bit-serial divider
   logic [DIVN_BITS-1:0]   dnum_ff, dnum_in;
   logic [DEN_BITS-1:0]    dden_ff, dden_in;
   logic [DEN_BITS-1:0]    drem_ff, drem_in;
   logic [5:0]             step_ff, step_in;

   // root unit
   logic [SQRT_SRC-1:0]    ssrc_ff, ssrc_in;
   logic [25:0]            srem_ff, srem_in;
   logic [SD_BITS-1:0]     root_ff, root_in;

   logic [VAR_BITS-1:0]    var_ff, var_in;
   logic [MEAN_BITS-1:0]   mean_ff, mean_in;

   // scan sequencer
   logic [CNT_BITS-1:0]    addr_ff, addr_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic                   first_ff, first_in;
   logic                   found_ff, found_in;
   logic [SAMPLE_BITS-1:0] prev_ff, prev_in;
   logic [SAMPLE_BITS-1:0] cand_ff, cand_in;
   logic [CNT_BITS-1:0]    ccount_ff, ccount_in;
   logic [CNT_BITS-1:0]    cum_ff, cum_in;
   logic                   phase_ff, phase_in;
   logic                   none_ff, none_in;
   logic [SAMPLE_BITS-1:0] min_ff, min_in;
   logic [SAMPLE_BITS-1:0] max_ff, max_in;
   logic [SAMPLE_BITS-1:0] meda_ff, meda_in;
   logic [SAMPLE_BITS-1:0] medb_ff, medb_in;
   logic [CNT_BITS-1:0]    best_ff, best_in;
   logic [CNT_BITS-1:0]    modes_ff, modes_in;
   logic [CNT_BITS-1:0]    emit_k_ff, emit_k_in;

   logic                   rsp_vld_ff, rsp_vld_in;
   logic [RSP_BITS-1:0]    rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;

   // datapath helpers
   logic [12:0]            drem_sh;
   logic                   dge;
   logic [27:0]            srem_sh;
   logic [27:0]            strial;
   logic                   sge;
   logic [CNT_BITS-1:0]    med_ia, med_ib, cum_top;
   logic                   out_free, is_last;
   logic [16:0]            med2;
   logic [13:0]            den_full;
   logic [44:0]            vdiff;

   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign mem_we  = req_tvalid && (state_ff == ST_LOAD) && (cnt_ff < CNT_BITS'(MAX_SAMPLES));
   assign drem_sh = {drem_ff, dnum_ff[DIVN_BITS-1]};
   assign dge     = drem_sh >= {1'b0, dden_ff};
   assign srem_sh = {srem_ff, ssrc_ff[SQRT_SRC-1 -: 2]};
   assign strial  = {2'b00, root_ff, 2'b01};
   assign sge     = srem_sh >= strial;
   assign med_ia  = (cnt_ff - CNT_BITS'(1)) >> 1;
   assign med_ib  = cnt_ff >> 1;
   assign cum_top = cum_ff + ccount_ff;
   assign out_free = !rsp_vld_ff || rsp_tready;
   assign is_last = none_ff || (emit_k_ff + CNT_BITS'(1) == modes_ff);
   assign med2    = {1'b0, meda_ff} + {1'b0, medb_ff};
   assign den_full = 14'(cnt_ff) * 14'(cnt_ff - CNT_BITS'(1));
   assign vdiff   = prod1_ff - {1'b0, prod2_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cnt_ff[ADDR_BITS-1:0]] <= req_tdata[SAMPLE_BITS-1:0];
      end
      rd_data_ff <= mem[addr_ff[ADDR_BITS-1:0]];
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      sum_in      = sum_ff;
      sq_in       = sq_ff;
      prod1_in    = prod1_ff;
      prod2_in    = prod2_ff;
      dnum_in     = dnum_ff;
      dden_in     = dden_ff;
      drem_in     = drem_ff;
      step_in     = step_ff;
      ssrc_in     = ssrc_ff;
      srem_in     = srem_ff;
      root_in     = root_ff;
      var_in      = var_ff;
      mean_in     = mean_ff;
      addr_in     = addr_ff;
      rd_vld_in   = 1'b0;
      first_in    = first_ff;
      found_in    = found_ff;
      prev_in     = prev_ff;
      cand_in     = cand_ff;
      ccount_in   = ccount_ff;
      cum_in      = cum_ff;
      phase_in    = phase_ff;
      none_in     = none_ff;
      min_in      = min_ff;
      max_in      = max_ff;
      meda_in     = meda_ff;
      medb_in     = medb_ff;
      best_in     = best_ff;
      modes_in    = modes_ff;
      emit_k_in   = emit_k_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;

      case (state_ff)
         ST_LOAD: begin
            if (mem_we) begin
               cnt_in = cnt_ff + CNT_BITS'(1);
               sum_in = sum_ff + SUM_BITS'(req_tdata);
               sq_in  = sq_ff + SQ_BITS'(32'(req_tdata) * 32'(req_tdata));
            end
            if (req_tvalid && req_tlast) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            // n * sum(x^2) and sum(x)^2, registered before the subtract
            prod1_in = 45'(cnt_ff) * 45'(sq_ff);
            prod2_in = 44'(sum_ff) * 44'(sum_ff);
            state_in = ST_VSET;
         end
         ST_VSET: begin
            if (cnt_ff < CNT_BITS'(2)) begin
               var_in   = '0;
               state_in = ST_MSET;
            end else begin
               dnum_in  = {vdiff[43:0], 8'h00};
               dden_in  = den_full[DEN_BITS-1:0];
               drem_in  = '0;
               step_in  = 6'(DIVN_BITS);
               state_in = ST_VDIV;
            end
         end
         ST_VDIV, ST_MDIV: begin
            drem_in = dge ? 12'(drem_sh - {1'b0, dden_ff}) : drem_sh[DEN_BITS-1:0];
            dnum_in = {dnum_ff[DIVN_BITS-2:0], dge};
            step_in = step_ff - 6'd1;
            if (step_ff == 6'd1) begin
               if (state_ff == ST_VDIV) begin
                  var_in   = (dnum_ff[DIVN_BITS-2:VAR_BITS-1] != '0) ? '1
                             : {dnum_ff[VAR_BITS-2:0], dge};
                  state_in = ST_MSET;
               end else begin
                  mean_in  = (dnum_ff[DIVN_BITS-2:MEAN_BITS-1] != '0) ? '1
                             : {dnum_ff[MEAN_BITS-2:0], dge};
                  ssrc_in  = {var_ff, 8'h00};
                  srem_in  = '0;
                  root_in  = '0;
                  step_in  = 6'(SD_BITS);
                  state_in = ST_SQRT;
               end
            end
         end
         ST_MSET: begin
            dnum_in  = DIVN_BITS'({sum_ff, 8'h00});
            dden_in  = DEN_BITS'(cnt_ff);
            drem_in  = '0;
            step_in  = 6'(DIVN_BITS);
            state_in = ST_MDIV;
         end
         ST_SQRT: begin
            // two source bits per step, one root bit out
            srem_in = sge ? 26'(srem_sh - strial) : srem_sh[25:0];
            root_in = {root_ff[SD_BITS-2:0], sge};
            ssrc_in = {ssrc_ff[SQRT_SRC-3:0], 2'b00};
            step_in = step_ff - 6'd1;
            if (step_ff == 6'd1) begin
               phase_in  = 1'b0;
               first_in  = 1'b1;
               found_in  = 1'b0;
               ccount_in = '0;
               cum_in    = '0;
               best_in   = '0;
               modes_in  = '0;
               addr_in   = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // one read per cycle; look for the smallest value above prev
            if (addr_ff < cnt_ff) begin
               rd_vld_in = 1'b1;
               addr_in   = addr_ff + CNT_BITS'(1);
            end else if (!rd_vld_ff) begin
               state_in = ST_STEP;
            end
            if (rd_vld_ff && (first_ff || rd_data_ff > prev_ff)) begin
               if (!found_ff || rd_data_ff < cand_ff) begin
                  cand_in   = rd_data_ff;
                  ccount_in = CNT_BITS'(1);
                  found_in  = 1'b1;
               end else if (rd_data_ff == cand_ff) begin
                  ccount_in = ccount_ff + CNT_BITS'(1);
               end
            end
         end
         ST_STEP: begin
            found_in  = 1'b0;
            ccount_in = '0;
            addr_in   = '0;
            if (!found_ff) begin
               if (!phase_ff && modes_ff == cnt_ff) begin
                  none_in  = 1'b1;
                  state_in = ST_EMIT;
               end else begin
                  none_in   = 1'b0;
                  phase_in  = 1'b1;
                  first_in  = 1'b1;
                  emit_k_in = '0;
                  state_in  = phase_ff ? ST_LOAD : ST_SCAN;
               end
            end else begin
               prev_in  = cand_ff;
               first_in = 1'b0;
               state_in = ST_SCAN;
               if (!phase_ff) begin
                  if (first_ff) begin
                     min_in = cand_ff;
                  end
                  max_in = cand_ff;
                  if (cum_ff <= med_ia && med_ia < cum_top) begin
                     meda_in = cand_ff;
                  end
                  if (cum_ff <= med_ib && med_ib < cum_top) begin
                     medb_in = cand_ff;
                  end
                  cum_in = cum_top;
                  if (ccount_ff > best_ff) begin
                     best_in  = ccount_ff;
                     modes_in = CNT_BITS'(1);
                  end else if (ccount_ff == best_ff) begin
                     modes_in = modes_ff + CNT_BITS'(1);
                  end
               end else if (ccount_ff == best_ff) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_last_in = is_last;
               rsp_data_in = {2'b00,
                              none_ff ? 7'd0 : modes_ff,
                              best_ff,
                              none_ff ? 16'd0 : cand_ff,
                              root_ff,
                              var_ff,
                              16'(max_ff - min_ff),
                              max_ff,
                              min_ff,
                              med2,
                              mean_ff,
                              cnt_ff};
               emit_k_in = emit_k_ff + CNT_BITS'(1);
               if (is_last) begin
                  cnt_in   = '0;
                  sum_in   = '0;
                  sq_in    = '0;
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         cnt_ff     <= '0;
         sum_ff     <= '0;
         sq_ff      <= '0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         sum_ff     <= sum_in;
         sq_ff      <= sq_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      prod1_ff    <= prod1_in;
      prod2_ff    <= prod2_in;
      dnum_ff     <= dnum_in;
      dden_ff     <= dden_in;
      drem_ff     <= drem_in;
      step_ff     <= step_in;
      ssrc_ff     <= ssrc_in;
      srem_ff     <= srem_in;
      root_ff     <= root_in;
      var_ff      <= var_in;
      mean_ff     <= mean_in;
      addr_ff     <= addr_in;
      first_ff    <= first_in;
      found_ff    <= found_in;
      prev_ff     <= prev_in;
      cand_ff     <= cand_in;
      ccount_ff   <= ccount_in;
      cum_ff      <= cum_in;
      phase_ff    <= phase_in;
      none_ff     <= none_in;
      min_ff      <= min_in;
      max_ff      <= max_in;
      meda_ff     <= meda_in;
      medb_ff     <= medb_in;
      best_ff     <= best_in;
      modes_ff    <= modes_in;
      emit_k_ff   <= emit_k_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   `ASSERT_NOW(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CNT_BITS'(MAX_SAMPLES), "held count over capacity")
   `ASSERT_NOW(a_rd_in_scan, clock, reset, rd_vld_ff, state_ff == ST_SCAN, "read data outside a sweep")
   `ASSERT_NOW(a_found_cnt, clock, reset, found_ff && state_ff == ST_STEP, ccount_ff != '0, "candidate with no count")
   `ASSERT_NEXT(a_emit_ready, clock, reset, state_ff == ST_EMIT && out_free, rsp_vld_ff, "emit lost a result")

endmodule
